/* design/chv_pkg.sv */
// ----------------------------------------------------------------------------
// chv_pkg
// Shared types and constants of the circle Hough vote accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package chv_pkg;

   // default sizes of the accumulator
   localparam int unsigned MAX_WIDTH_DEF  = 256;
   localparam int unsigned MAX_HEIGHT_DEF = 256;
   localparam int unsigned MAX_RADIUS_DEF = 127;

   // field widths
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned POS_W    = 8;
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned RADIUS_W = 7;
   localparam int unsigned SIZE_W   = 9;

   // point coordinates: center 0..255 plus or minus up to 127
   localparam int unsigned COORD_W  = 10;
   // midpoint decision variable
   localparam int unsigned D_W      = 18;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_VOTE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_WIDTH  = 2'd1,
      REG_HEIGHT = 2'd2
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CLEAR  = 6'b000010,
      ST_READ   = 6'b000100,
      ST_AXIS   = 6'b001000,
      ST_WALK   = 6'b010000,
      ST_POINTS = 6'b100000
   } state_type;

endpackage

`default_nettype wire

/* design/chv_ram.sv */
// ----------------------------------------------------------------------------
// chv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module chv_ram #(
   parameter int unsigned DATA_W = 16,
   parameter int unsigned DEPTH  = 65536,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* design/circle_hough_vote_accumulator_core.sv */
// ----------------------------------------------------------------------------
// circle_hough_vote_accumulator_core
// Fixed-radius circle Hough voting into a RAM accumulator.
// ----------------------------------------------------------------------------
// Read request: the RAM read and stage p1 are registered together, then the rsp register strobes rsp_valid.
// Vote request: busy through the axis points, then per octant row the x walk
//   steps plus eight mirrored points (four on the diagonal); a zero pixel or bad radius is ignored.
// Clear request: one RAM word per cycle, busy until all MAX_WIDTH*MAX_HEIGHT words are zeroed.
// Reset runs the same clearing pass; csr writes are taken during it.
// The receiver cannot stall; results are never held back.
`default_nettype none

module circle_hough_vote_accumulator_core #(
   parameter int unsigned MAX_WIDTH  = chv_pkg::MAX_WIDTH_DEF,
   parameter int unsigned MAX_HEIGHT = chv_pkg::MAX_HEIGHT_DEF,
   parameter int unsigned MAX_RADIUS = chv_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [chv_pkg::KIND_W-1:0]         req_kind,
   input  wire logic [chv_pkg::POS_W-1:0]          req_col,
   input  wire logic [chv_pkg::POS_W-1:0]          req_row,
   input  wire logic [chv_pkg::PIX_W-1:0]          req_pixel_value,
   // result channel
   output logic                                    rsp_valid,
   output logic      [chv_pkg::COUNT_W-1:0]        rsp_vote_count,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [chv_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [chv_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [chv_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                    pready
);

   localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned W_CAP  = (MAX_WIDTH  > 511) ? 511 : MAX_WIDTH;
   localparam int unsigned H_CAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

   localparam int unsigned COORD_W  = chv_pkg::COORD_W;
   localparam int unsigned D_W      = chv_pkg::D_W;
   localparam int unsigned SIZE_W   = chv_pkg::SIZE_W;
   localparam int unsigned RADIUS_W = chv_pkg::RADIUS_W;
   localparam int unsigned POS_W    = chv_pkg::POS_W;
   localparam int unsigned COUNT_W  = chv_pkg::COUNT_W;

   // ------------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------------
   chv_pkg::state_type          state_ff, state_in;
   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;
   logic [POS_W-1:0]            cx_ff, cx_in;
   logic [POS_W-1:0]            cy_ff, cy_in;
   logic [RADIUS_W-1:0]         x0_ff, x0_in;
   logic [RADIUS_W-1:0]         y0_ff, y0_in;
   logic signed [D_W-1:0]       d_ff, d_in;
   logic [2:0]                  k_ff, k_in;

   logic                        p1_valid_ff, p1_valid_in;
   logic                        p1_vote_ff, p1_vote_in;
   logic                        p1_hit_ff, p1_hit_in;
   logic [ADDR_W-1:0]           p1_addr_ff, p1_addr_in;

   logic                        wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0]           wb_addr_ff, wb_addr_in;
   logic [COUNT_W-1:0]          wb_data_ff, wb_data_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]          rsp_count_ff, rsp_count_in;

   logic [RADIUS_W-1:0]         radius_ff, radius_in;
   logic [SIZE_W-1:0]           width_ff, width_in;
   logic [SIZE_W-1:0]           height_ff, height_in;

   // ------------------------------------------------------------------------
   // RAM
   // ------------------------------------------------------------------------
   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   logic [COUNT_W-1:0]          mem_wr_data;
   logic                        mem_rd_en;
   logic [ADDR_W-1:0]           mem_rd_addr;
   logic [COUNT_W-1:0]          mem_rd_data;

   chv_ram #(
      .DATA_W (COUNT_W),
      .DEPTH  (DEPTH)
   ) u_vote_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIZE_W-1:0] x,
                                                  input logic [SIZE_W-1:0] y);
      return ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   endfunction

   // ------------------------------------------------------------------------
   // combinational
   // ------------------------------------------------------------------------
   logic [SIZE_W-1:0]           eff_w, eff_h;
   logic                        accept;
   logic                        radius_ok;
   logic [RADIUS_W-1:0]         mag_x, mag_y;
   logic                        neg_x, neg_y;
   logic signed [COORD_W-1:0]   px, py;
   logic                        pt_active, pt_in;
   logic [ADDR_W-1:0]           pt_addr;
   logic                        req_in;
   logic [COUNT_W-1:0]          cur;
   logic                        pts_last;
   logic [RADIUS_W:0]           y0_next;
   logic signed [D_W-1:0]       d_up_y, d_dn_x;

   assign eff_w = (width_ff  > SIZE_W'(W_CAP)) ? SIZE_W'(W_CAP) : width_ff;
   assign eff_h = (height_ff > SIZE_W'(H_CAP)) ? SIZE_W'(H_CAP) : height_ff;

   assign accept    = start && (state_ff == chv_pkg::ST_IDLE);
   assign radius_ok = (radius_ff != '0) && (32'(radius_ff) <= 32'(MAX_RADIUS));

   // point offsets: axis points, then (+-x0,+-y0) and swapped (+-y0,+-x0)
   always_comb begin
      mag_x = '0;
      mag_y = '0;
      neg_x = k_ff[0];
      neg_y = k_ff[0];
      if (state_ff == chv_pkg::ST_AXIS) begin
         mag_x = k_ff[1] ? '0 : radius_ff;
         mag_y = k_ff[1] ? radius_ff : '0;
      end else begin
         mag_x = k_ff[2] ? y0_ff : x0_ff;
         mag_y = k_ff[2] ? x0_ff : y0_ff;
         neg_y = k_ff[1];
      end
   end

   always_comb begin
      logic signed [COORD_W-1:0] dx, dy;
      dx = $signed(COORD_W'(mag_x));
      dy = $signed(COORD_W'(mag_y));
      px = $signed(COORD_W'(cx_ff)) + (neg_x ? -dx : dx);
      py = $signed(COORD_W'(cy_ff)) + (neg_y ? -dy : dy);
   end

   assign pt_active = (state_ff == chv_pkg::ST_AXIS) || (state_ff == chv_pkg::ST_POINTS);
   assign pt_in     = !px[COORD_W-1] && !py[COORD_W-1] &&
                      (px[SIZE_W-1:0] < eff_w) && (py[SIZE_W-1:0] < eff_h);
   assign pt_addr   = cell_addr(px[SIZE_W-1:0], py[SIZE_W-1:0]);

   assign req_in = ({1'b0, req_col} < eff_w) && ({1'b0, req_row} < eff_h);

   // forward the write made on the edge that also sampled this read
   assign cur = (wb_valid_ff && (wb_addr_ff == p1_addr_ff)) ? wb_data_ff : mem_rd_data;

   assign pts_last = (x0_ff == y0_ff) ? (k_ff == 3'd3) : (k_ff == 3'd7);
   assign y0_next  = {1'b0, y0_ff} + 1'b1;
   assign d_up_y   = d_ff + $signed(D_W'({y0_ff, 1'b1}));
   assign d_dn_x   = d_ff - $signed(D_W'({x0_ff, 1'b0})) + $signed(D_W'(2));

   // RAM ports
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = pt_addr;
      if (accept && (req_kind == chv_pkg::KIND_READ)) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = cell_addr({1'b0, req_col}, {1'b0, req_row});
      end else if (pt_active && pt_in) begin
         mem_rd_en   = 1'b1;
      end

      if (state_ff == chv_pkg::ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = p1_valid_ff && p1_vote_ff;
         mem_wr_addr = p1_addr_ff;
         mem_wr_data = (cur == chv_pkg::COUNT_MAX) ? cur : cur + 1'b1;
      end
   end

   // sequencer and pipeline
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      x0_in       = x0_ff;
      y0_in       = y0_ff;
      d_in        = d_ff;
      k_in        = k_ff;

      p1_valid_in = mem_rd_en;
      p1_vote_in  = pt_active;
      p1_hit_in   = !pt_active ? req_in : 1'b1;
      p1_addr_in  = mem_rd_addr;

      wb_valid_in = mem_wr_en && (state_ff != chv_pkg::ST_CLEAR);
      wb_addr_in  = mem_wr_addr;
      wb_data_in  = mem_wr_data;

      rsp_valid_in = p1_valid_ff && !p1_vote_ff;
      rsp_count_in = p1_hit_ff ? cur : '0;

      case (state_ff)
         chv_pkg::ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  chv_pkg::KIND_VOTE: begin
                     if ((req_pixel_value != '0) && radius_ok) begin
                        state_in = chv_pkg::ST_AXIS;
                        cx_in    = req_col;
                        cy_in    = req_row;
                        x0_in    = radius_ff;
                        y0_in    = '0;
                        d_in     = -$signed(D_W'(radius_ff));
                        k_in     = '0;
                     end
                  end
                  chv_pkg::KIND_READ:  state_in = chv_pkg::ST_READ;
                  chv_pkg::KIND_CLEAR: begin
                     state_in    = chv_pkg::ST_CLEAR;
                     clr_addr_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         chv_pkg::ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = chv_pkg::ST_IDLE;
            end
         end
         chv_pkg::ST_READ: begin
            state_in = chv_pkg::ST_IDLE;
         end
         chv_pkg::ST_AXIS: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 3'd3) begin
               k_in  = '0;
               y0_in = RADIUS_W'(1);
               d_in  = d_up_y;
               state_in = (x0_ff > RADIUS_W'(1)) ? chv_pkg::ST_WALK : chv_pkg::ST_IDLE;
            end
         end
         chv_pkg::ST_WALK: begin
            // step x0 down while x0*x0 - x0 + y0*y0 - r*r > 0
            if (!d_ff[D_W-1] && (d_ff != '0)) begin
               x0_in = x0_ff - 1'b1;
               d_in  = d_dn_x;
            end else begin
               state_in = chv_pkg::ST_POINTS;
               k_in     = '0;
            end
         end
         chv_pkg::ST_POINTS: begin
            k_in = k_ff + 1'b1;
            if (pts_last) begin
               k_in  = '0;
               y0_in = y0_next[RADIUS_W-1:0];
               d_in  = d_up_y;
               state_in = (y0_next < {1'b0, x0_ff}) ? chv_pkg::ST_WALK : chv_pkg::ST_IDLE;
            end
         end
         default: state_in = chv_pkg::ST_IDLE;
      endcase
   end

   // register writes
   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (psel && penable && pwrite) begin
         case (paddr[3:2])
            chv_pkg::REG_RADIUS: radius_in = pwdata[RADIUS_W-1:0];
            chv_pkg::REG_WIDTH:  width_in  = pwdata[SIZE_W-1:0];
            chv_pkg::REG_HEIGHT: height_in = pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         chv_pkg::REG_RADIUS: prdata = chv_pkg::CSR_DATA_W'(radius_ff);
         chv_pkg::REG_WIDTH:  prdata = chv_pkg::CSR_DATA_W'(width_ff);
         chv_pkg::REG_HEIGHT: prdata = chv_pkg::CSR_DATA_W'(height_ff);
         default:             prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // flops
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= chv_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RADIUS_W'(1);
         width_ff     <= SIZE_W'(256);
         height_ff    <= SIZE_W'(256);
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         p1_valid_ff  <= p1_valid_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      x0_ff        <= x0_in;
      y0_ff        <= y0_in;
      d_ff         <= d_in;
      k_ff         <= k_in;
      p1_vote_ff   <= p1_vote_in;
      p1_hit_ff    <= p1_hit_in;
      p1_addr_ff   <= p1_addr_in;
      wb_addr_ff   <= wb_addr_in;
      wb_data_ff   <= wb_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy           = (state_ff != chv_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vote_count = rsp_count_ff;
   assign pready         = 1'b1;

endmodule

`default_nettype wire

/* bench/tb_circle_hough_vote_accumulator_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_hough_vote_accumulator_core
// Sends vote, read and clear requests under several radius and image size
// settings. A tally of the accumulator traces each circle and predicts every
// read; returned counts are checked in order, and register readback too.
// ----------------------------------------------------------------------------
module tb_circle_hough_vote_accumulator_core;
   import chv_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int unsigned CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam int PHASES = 9;
   localparam int PHASE_REQUESTS = 80;
   localparam int STACK_VOTES = 24;

   class vote_tally;
      bit [COUNT_W-1:0]  cells [CELLS];
      bit [RADIUS_W-1:0] radius;
      bit [SIZE_W-1:0]   width;
      bit [SIZE_W-1:0]   height;
      bit [COUNT_W-1:0]  pending_counts [$];
      int unsigned       hit_cells [$];
      int                errors;

      function new();
         errors = 0;
         radius = 1;
         width  = 256;
         height = 256;
         foreach (cells[i]) cells[i] = '0;
      endfunction

      function int span(bit [SIZE_W-1:0] v, int lim);
         return (v > lim) ? lim : int'(v);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function void bump(int px, int py);
         int unsigned idx;
         if (px < 0 || py < 0 || px >= span(width, MAX_WIDTH_DEF) ||
             py >= span(height, MAX_HEIGHT_DEF))
            return;
         idx = py * MAX_WIDTH_DEF + px;
         if (cells[idx] != COUNT_MAX) cells[idx]++;
         hit_cells.push_back(idx);
         if (hit_cells.size() > 512) void'(hit_cells.pop_front());
      endfunction

      // axis points, then one octant walked and mirrored eight ways
      function void trace_circle(int cx, int cy, int r);
         int x;
         int y;
         int rr;
         rr = r * r;
         x = r;
         bump(cx + r, cy);
         bump(cx - r, cy);
         bump(cx, cy + r);
         bump(cx, cy - r);
         for (y = 1; y < x; y++) begin
            while (x * x > rr - y * y + x) x--;
            bump(cx + x, cy + y);
            bump(cx - x, cy + y);
            bump(cx + x, cy - y);
            bump(cx - x, cy - y);
            if (x != y) begin
               bump(cx + y, cy + x);
               bump(cx - y, cy + x);
               bump(cx + y, cy - x);
               bump(cx - y, cy - x);
            end
         end
      endfunction

      function void write_reg(reg_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            REG_RADIUS: radius = value[RADIUS_W-1:0];
            REG_WIDTH:  width  = value[SIZE_W-1:0];
            REG_HEIGHT: height = value[SIZE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] col,
                                 logic [POS_W-1:0] row, logic [PIX_W-1:0] pix);
         if (kind == KIND_VOTE) begin
            if (pix != 0 && radius >= 1 && radius <= MAX_RADIUS_DEF)
               trace_circle(int'(col), int'(row), int'(radius));
         end else if (kind == KIND_READ) begin
            if (col < span(width, MAX_WIDTH_DEF) && row < span(height, MAX_HEIGHT_DEF))
               pending_counts.push_back(cells[row * MAX_WIDTH_DEF + col]);
            else
               pending_counts.push_back('0);
         end else if (kind == KIND_CLEAR) begin
            foreach (cells[i]) cells[i] = '0;
            hit_cells.delete();
         end
      endfunction

      task check_result(logic [COUNT_W-1:0] got);
         bit [COUNT_W-1:0] want;
         if (pending_counts.size() == 0) begin
            report($sformatf("vote_count %0d with no read outstanding", got));
         end else begin
            want = pending_counts.pop_front();
            if (got !== want)
               report($sformatf("vote_count %0d, predicted %0d", got, want));
         end
      endtask

      function int unsigned pick_hit_cell();
         if (hit_cells.size() == 0) return $urandom_range(0, CELLS - 1);
         return hit_cells[$urandom_range(0, hit_cells.size() - 1)];
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind;
   logic [POS_W-1:0]      req_col;
   logic [POS_W-1:0]      req_row;
   logic [PIX_W-1:0]      req_pixel_value;
   logic                  rsp_valid;
   logic [COUNT_W-1:0]    rsp_vote_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vote_tally tally = new();
   bit        idle_gaps;
   longint    cycle_count = 0;

   circle_hough_vote_accumulator_core DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_vote_count  (rsp_vote_count),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // results first: a request taken at this edge cannot be answered yet
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tally.check_result(rsp_vote_count);
         if (start && !busy)
            tally.note_request(req_kind, req_col, req_row, req_pixel_value);
      end
   end

   // start stays high when the next request follows at once
   task automatic send_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] col,
                               logic [POS_W-1:0] row, logic [PIX_W-1:0] pix);
      int gap;
      req_kind        <= kind;
      req_col         <= col;
      req_row         <= row;
      req_pixel_value <= pix;
      start           <= 1'b1;
      do @(posedge clock); while (busy);
      if (idle_gaps && $urandom_range(0, 99) < 31) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 80) : $urandom_range(1, 8);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic read_hit_cell();
      int unsigned idx;
      idx = tally.pick_hit_cell();
      send_request(KIND_READ, POS_W'(idx % MAX_WIDTH_DEF), POS_W'(idx / MAX_WIDTH_DEF),
                   PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (busy || tally.pending_counts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write, then read back through a second transfer with psel held
   task automatic write_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      tally.write_reg(idx, value);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== value)
         tally.report($sformatf("register %s reads %0d, wrote %0d", idx.name(), prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_image(int r, int w, int h);
      write_register(REG_RADIUS, r);
      write_register(REG_WIDTH, w);
      write_register(REG_HEIGHT, h);
   endtask

   task automatic random_request();
      int               roll;
      int               wlim;
      int               hlim;
      logic [POS_W-1:0] c;
      logic [POS_W-1:0] r;
      logic [PIX_W-1:0] pix;
      wlim = tally.span(tally.width, MAX_WIDTH_DEF);
      hlim = tally.span(tally.height, MAX_HEIGHT_DEF);
      roll = $urandom_range(0, 999);
      c = POS_W'($urandom_range(0, 255));
      r = POS_W'($urandom_range(0, 255));
      pix = PIX_W'($urandom_range(0, 255));
      if (roll < 4) begin
         send_request(KIND_CLEAR, c, r, pix);
      end else if (roll < 24) begin
         send_request(KIND_UNUSED, c, r, pix);
      end else if (roll < 320) begin
         if ($urandom_range(0, 3) != 0) read_hit_cell();
         else send_request(KIND_READ, c, r, pix);
      end else begin
         pix = (roll < 360) ? '0 : PIX_W'($urandom_range(1, 255));
         if ($urandom_range(0, 9) < 7 && wlim > 0 && hlim > 0) begin
            c = POS_W'($urandom_range(0, wlim - 1));
            r = POS_W'($urandom_range(0, hlim - 1));
         end
         send_request(KIND_VOTE, c, r, pix);
      end
   endtask

   initial begin
      int phase;
      int n;
      int radius_plan [PHASES];
      int width_plan  [PHASES];
      int height_plan [PHASES];

      radius_plan = '{3, 127, 5, 1, 20, 64, 2, 0, 11};
      width_plan  = '{256, 256, 16, 1, 511, 128, 8, 200, 40};
      height_plan = '{256, 200, 16, 1, 300, 256, 511, 100, 25};

      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= KIND_VOTE;
      req_col         <= '0;
      req_row         <= '0;
      req_pixel_value <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      idle_gaps = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // store is cleared after reset
      while (busy) @(posedge clock);

      // reset settings: unit circles at the corners
      send_request(KIND_READ, 8'd0, 8'd0, 8'd0);
      send_request(KIND_VOTE, 8'd0, 8'd0, 8'd255);
      send_request(KIND_VOTE, 8'd255, 8'd255, 8'd1);
      send_request(KIND_VOTE, 8'd10, 8'd10, 8'd0);
      send_request(KIND_UNUSED, 8'd1, 8'd0, 8'd255);
      send_request(KIND_READ, 8'd1, 8'd0, 8'd0);
      send_request(KIND_READ, 8'd0, 8'd1, 8'd0);
      send_request(KIND_READ, 8'd255, 8'd254, 8'd0);
      send_request(KIND_READ, 8'd11, 8'd10, 8'd0);
      quiesce();

      // largest radius, width above its maximum, centers partly off the image
      set_image(127, 511, 256);
      send_request(KIND_VOTE, 8'd128, 8'd128, 8'h80);
      send_request(KIND_VOTE, 8'd0, 8'd255, 8'h7f);
      send_request(KIND_READ, 8'd255, 8'd128, 8'd0);
      send_request(KIND_READ, 8'd128, 8'd1, 8'd0);
      read_hit_cell();
      read_hit_cell();
      read_hit_cell();
      quiesce();

      // zero radius: votes ignored
      set_image(0, 256, 256);
      send_request(KIND_VOTE, 8'd50, 8'd50, 8'd1);
      send_request(KIND_READ, 8'd51, 8'd50, 8'd0);
      quiesce();

      // empty image
      set_image(1, 0, 0);
      send_request(KIND_VOTE, 8'd5, 8'd5, 8'd1);
      send_request(KIND_READ, 8'd0, 8'd0, 8'd0);
      send_request(KIND_READ, 8'd255, 8'd255, 8'd0);
      quiesce();

      set_image(2, 256, 256);
      send_request(KIND_CLEAR, 8'd0, 8'd0, 8'd0);
      send_request(KIND_READ, 8'd255, 8'd128, 8'd0);
      quiesce();

      // stack votes on four cells, back to back
      set_image(1, 256, 256);
      idle_gaps = 1'b0;
      repeat (STACK_VOTES)
         send_request(KIND_VOTE, 8'd101, 8'd100, PIX_W'($urandom_range(1, 255)));
      send_request(KIND_READ, 8'd100, 8'd100, 8'd0);
      send_request(KIND_READ, 8'd102, 8'd100, 8'd0);
      send_request(KIND_READ, 8'd101, 8'd101, 8'd0);
      send_request(KIND_READ, 8'd101, 8'd99, 8'd0);
      quiesce();

      for (phase = 0; phase < PHASES; phase++) begin
         set_image(radius_plan[phase], width_plan[phase], height_plan[phase]);
         idle_gaps = (phase != 4);
         for (n = 0; n < PHASE_REQUESTS; n++) random_request();
         quiesce();
      end

      if (tally.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

/* sim.f */
design/chv_pkg.sv
design/chv_ram.sv
design/circle_hough_vote_accumulator_core.sv
bench/tb_circle_hough_vote_accumulator_core.sv
